// ----- hdl/rgbls_pkg.sv -----
// Shared types and constants for the RGB LED strip frame builder.
// Used by rgbls_colour_store and rgb_led_strip_frame_builder_unit; no dependencies.
package rgbls_pkg;

   // Store geometry.
   localparam int MAX_LEDS  = 62;
   localparam int LED_IDX_W = $clog2(MAX_LEDS);
   localparam int COLOUR_W  = 24;

   // Word and digit widths.
   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 32;
   localparam int BYTES_W  = 2;
   localparam int BRIGHT_W = 5;
   localparam int COUNT_W  = 6;
   localparam int CSR_DATA_W = 6;

   // Field placement in the request tdata bus.
   localparam int IDX_LSB   = 0;
   localparam int RED_LSB   = IDX_LSB + LED_IDX_W;
   localparam int GREEN_LSB = RED_LSB + BYTE_W;
   localparam int BLUE_LSB  = GREEN_LSB + BYTE_W;

   // Constant parts of the frame words.
   localparam logic [2:0]        LED_HEAD_BITS = 3'b111;
   localparam logic [BYTE_W-1:0] START_BYTE    = 8'h00;
   localparam logic [BYTE_W-1:0] END_BYTE      = 8'hFF;
   localparam logic [BYTES_W-1:0] LAST_BYTE    = 2'd3;

   // Register reset values.
   localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 5'd31;
   localparam logic [COUNT_W-1:0]  COUNT_RESET  = 6'd62;

   // Register indexes on the configuration port.
   localparam logic CSR_BRIGHTNESS = 1'b0;
   localparam logic CSR_LED_COUNT  = 1'b1;

   // Request codes carried in tuser.
   typedef enum logic [1:0] {
      REQ_SET    = 2'd0,
      REQ_CLEAR  = 2'd1,
      REQ_UPDATE = 2'd2
   } req_code_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_PACK,
      ST_OFFER
   } state_type;

   // Kind of frame word being assembled.
   typedef enum logic [1:0] {
      KIND_START,
      KIND_LED,
      KIND_END
   } word_kind_type;

   // Access command from the sequencer to the colour store.
   typedef struct packed {
      logic                 wr_en;
      logic [LED_IDX_W-1:0] wr_addr;
      logic [COLOUR_W-1:0]  wr_data;
      logic                 rd_en;
      logic [LED_IDX_W-1:0] rd_addr;
   } store_cmd_type;

endpackage

// ----- hdl/rgbls_colour_store.sv -----
// Colour store: one 24-bit colour per LED, one write and one registered read a cycle.
// Depends on rgbls_pkg; entries never written since reset read as zero.
module rgbls_colour_store (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rgbls_pkg::store_cmd_type               cmd,
   output logic [rgbls_pkg::COLOUR_W-1:0]         rd_data
);
   import rgbls_pkg::*;

   logic [COLOUR_W-1:0] mem_ff [MAX_LEDS];
   logic [MAX_LEDS-1:0] valid_ff;
   logic [COLOUR_W-1:0] rd_data_ff;

   // Valid bits stand in for clearing the whole array at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[cmd.wr_addr] <= 1'b1;
      end
   end

   // Array write.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.wr_addr] <= cmd.wr_data;
      end
   end

   // Registered read; an entry not yet written reads as zero.
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= valid_ff[cmd.rd_addr] ? mem_ff[cmd.rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/rgb_led_strip_frame_builder_unit.sv -----
// Top level of the RGB LED strip frame builder: request decode, frame sequencer,
// byte-serial word packer and output register. Depends on rgbls_pkg and rgbls_colour_store.

// A set or clear request is one store write; requests whose LED index is at or above
// the LED count (capped at 62) are dropped, as is request code 3.
// An update emits a start word of zeros, one word per LED in use and an end word of
// all ones marked with tlast. Each word is assembled one byte per cycle in a shift
// register; a start or end word goes through four byte shifts and the hand-off to the
// output register, and an LED word through a store read, four byte shifts and that hand-off.
// No request is taken while an update is in progress, but the next request is taken
// while the end word still waits.
module rgb_led_strip_frame_builder_unit (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // led_index[5:0], red[13:6], green[21:14], blue[29:22]
   input  logic [1:0]  req_tuser,  // req_type[1:0]
   // Frame word stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // frame_word[31:0]
   output logic        rsp_tlast,
   // Register write port.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [5:0]  csr_data
);
   import rgbls_pkg::*;

   state_type            state_ff,    state_in;
   word_kind_type        kind_ff,     kind_in;
   logic [LED_IDX_W-1:0] led_ff,      led_in;
   logic [BYTES_W-1:0]   byte_cnt_ff, byte_cnt_in;
   logic [WORD_W-1:0]    shift_ff,    shift_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]    rsp_data_ff,  rsp_data_in;
   logic                 rsp_last_ff,  rsp_last_in;
   logic [BRIGHT_W-1:0]  brightness_ff;
   logic [COUNT_W-1:0]   led_count_ff;

   store_cmd_type        store_cmd;
   logic [COLOUR_W-1:0]  store_rd_data;
   logic [COUNT_W-1:0]   active_leds;
   logic [LED_IDX_W:0]   led_next;
   logic [BYTE_W-1:0]    pack_byte;
   req_code_type         req_code;
   logic [LED_IDX_W-1:0] req_idx;
   logic [COLOUR_W-1:0]  req_colour;

   rgbls_colour_store u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (store_cmd),
      .rd_data (store_rd_data)
   );

   // Request fields and the effective LED count.
   assign req_code    = req_code_type'(req_tuser);
   assign req_idx     = req_tdata[IDX_LSB +: LED_IDX_W];
   assign req_colour  = {req_tdata[RED_LSB +: BYTE_W], req_tdata[GREEN_LSB +: BYTE_W],
                         req_tdata[BLUE_LSB +: BYTE_W]};
   assign active_leds = (led_count_ff > COUNT_W'(MAX_LEDS)) ? COUNT_W'(MAX_LEDS)
                                                            : led_count_ff;
   assign led_next    = {1'b0, led_ff} + 1'b1;

   // Byte that enters the packing shift register this cycle.
   always_comb begin
      pack_byte = START_BYTE;
      case (kind_ff)
         KIND_START: pack_byte = START_BYTE;
         KIND_END:   pack_byte = END_BYTE;
         KIND_LED: begin
            case (byte_cnt_ff)
               2'd0:    pack_byte = {LED_HEAD_BITS, brightness_ff};
               2'd1:    pack_byte = store_rd_data[2*BYTE_W +: BYTE_W];
               2'd2:    pack_byte = store_rd_data[BYTE_W +: BYTE_W];
               default: pack_byte = store_rd_data[0 +: BYTE_W];
            endcase
         end
         default:    pack_byte = START_BYTE;
      endcase
   end

   // Sequencer: next state, store commands and output register loading.
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      led_in       = led_ff;
      byte_cnt_in  = byte_cnt_ff;
      shift_in     = shift_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      store_cmd    = '0;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (req_code)
                  REQ_SET: begin
                     if ({1'b0, req_idx} < {1'b0, active_leds}) begin
                        store_cmd.wr_en   = 1'b1;
                        store_cmd.wr_addr = req_idx;
                        store_cmd.wr_data = req_colour;
                     end
                  end
                  REQ_CLEAR: begin
                     if ({1'b0, req_idx} < {1'b0, active_leds}) begin
                        store_cmd.wr_en   = 1'b1;
                        store_cmd.wr_addr = req_idx;
                        store_cmd.wr_data = '0;
                     end
                  end
                  REQ_UPDATE: begin
                     kind_in     = KIND_START;
                     led_in      = '0;
                     byte_cnt_in = '0;
                     state_in    = ST_PACK;
                  end
                  default: ;
               endcase
            end
         end
         ST_FETCH: begin
            store_cmd.rd_en   = 1'b1;
            store_cmd.rd_addr = led_ff;
            state_in          = ST_PACK;
         end
         ST_PACK: begin
            shift_in    = {shift_ff[WORD_W-BYTE_W-1:0], pack_byte};
            byte_cnt_in = byte_cnt_ff + 1'b1;
            if (byte_cnt_ff == LAST_BYTE) begin
               state_in = ST_OFFER;
            end
         end
         ST_OFFER: begin
            // Hand the word over once the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = shift_ff;
               rsp_last_in  = (kind_ff == KIND_END);
               unique case (kind_ff)
                  KIND_START: begin
                     if (active_leds != '0) begin
                        kind_in  = KIND_LED;
                        led_in   = '0;
                        state_in = ST_FETCH;
                     end else begin
                        kind_in  = KIND_END;
                        state_in = ST_PACK;
                     end
                  end
                  KIND_LED: begin
                     if (led_next < {1'b0, active_leds}) begin
                        led_in   = led_next[LED_IDX_W-1:0];
                        state_in = ST_FETCH;
                     end else begin
                        kind_in  = KIND_END;
                        state_in = ST_PACK;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= KIND_START;
         led_ff       <= '0;
         byte_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         led_ff       <= led_in;
         byte_cnt_ff  <= byte_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Configuration registers; the port never stalls.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BRIGHT_RESET;
         led_count_ff  <= COUNT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BRIGHTNESS: brightness_ff <= csr_data[BRIGHT_W-1:0];
            CSR_LED_COUNT:  led_count_ff  <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // An LED word is only ever offered for an LED in use.
   a_led_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OFFER && kind_ff == KIND_LED) |-> ({1'b0, led_ff} < {1'b0, active_leds}))
      else $error("LED word offered beyond the LED count");

   // The store is written only by a request taken in the idle state.
   a_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      store_cmd.wr_en |-> (state_ff == ST_IDLE && req_tvalid))
      else $error("store write outside an accepted request");

   // The word marked last is the all-ones end word.
   a_end_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata == '1))
      else $error("last word is not the end word");

   // LED words carry the current brightness in their head byte.
   a_led_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast && rsp_tdata[WORD_W-1 -: 3] == LED_HEAD_BITS)
      |-> (rsp_tdata[WORD_W-4 -: BRIGHT_W] == brightness_ff))
      else $error("LED word head byte does not match brightness");

   // A word handed over by the sequencer appears on the output next cycle.
   a_word_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OFFER && (!rsp_valid_ff || rsp_tready)) |=> rsp_tvalid)
      else $error("offered word did not reach the output register");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for rgb_led_strip_frame_builder_unit: directed and random requests,
// random idling on both streams, frame words checked against a scoreboard with its own store.
// Depends on rgbls_pkg and the RTL of the frame builder.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rgbls_pkg::*;

   // The fourth request code has no meaning and must be ignored.
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 400;

   typedef struct {
      logic [31:0] word;
      logic        last;
   } frame_word_type;

   // Tracks the colour store and registers, and the frame words still to come.
   class led_frame_model;
      logic [23:0]    colours [0:MAX_LEDS-1];
      logic [4:0]     brightness;
      logic [5:0]     led_count;
      frame_word_type frame_words[$];
      int             errors;

      function new();
         foreach (colours[i]) colours[i] = '0;
         brightness = 5'd31;
         led_count  = 6'd62;
         errors     = 0;
      endfunction

      function int active_leds();
         return (led_count > MAX_LEDS) ? MAX_LEDS : int'(led_count);
      endfunction

      function int pending();
         return frame_words.size();
      endfunction

      function void write_reg(logic index, logic [5:0] value);
         if (index == CSR_BRIGHTNESS) begin
            brightness = value[4:0];
         end else begin
            led_count = value;
         end
      endfunction

      // Apply one accepted request word and queue the frame words it causes.
      function void take_request(logic [1:0] kind, logic [5:0] idx,
                                 logic [7:0] red, logic [7:0] green, logic [7:0] blue);
         int             active;
         logic [7:0]     head;
         frame_word_type fw;
         active = active_leds();
         head   = 8'hE0 | {3'b000, brightness};
         case (kind)
            REQ_SET: begin
               if (idx < active) colours[idx] = {red, green, blue};
            end
            REQ_CLEAR: begin
               if (idx < active) colours[idx] = '0;
            end
            REQ_UPDATE: begin
               fw.word = '0;
               fw.last = 1'b0;
               frame_words.push_back(fw);
               for (int i = 0; i < active; i++) begin
                  fw.word = {head, colours[i]};
                  frame_words.push_back(fw);
               end
               fw.word = '1;
               fw.last = 1'b1;
               frame_words.push_back(fw);
            end
            default: ;
         endcase
      endfunction

      // Compare one accepted frame word with the oldest one expected.
      function void check_word(logic [31:0] word, logic last);
         frame_word_type fw;
         if (frame_words.size() == 0) begin
            $display("%0t unexpected frame word: expected none, actual %h last %b",
                     $time, word, last);
            errors++;
         end else begin
            fw = frame_words.pop_front();
            if (word !== fw.word) begin
               $display("%0t frame word mismatch: expected %h, actual %h",
                        $time, fw.word, word);
               errors++;
            end
            if (last !== fw.last) begin
               $display("%0t last flag mismatch: expected %b, actual %b",
                        $time, fw.last, last);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = 1'b0;
   logic [5:0]  csr_data   = '0;

   led_frame_model frames = new();
   bit req_gaps   = 1'b0;
   bit rsp_stalls = 1'b0;
   bit long_hold  = 1'b0;

   always #1 clock = ~clock;

   rgb_led_strip_frame_builder_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Frame sink: random stall bursts, plus one long hold-off on request.
   initial begin
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (rsp_stalls && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Every accepted frame word goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) frames.check_word(rsp_tdata, rsp_tlast);
   end

   // Offer one request word, with an optional idle burst first.
   task automatic send_request(logic [1:0] kind, logic [5:0] idx,
                               logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      if (req_gaps && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      // Fields from bit 0 up: led_index, red, green, blue, two zero bits.
      req_tdata  <= {2'b00, blue, green, red, idx};
      do @(posedge clock); while (!req_tready);
      frames.take_request(kind, idx, red, green, blue);
   endtask

   task automatic write_reg(logic index, logic [5:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      frames.write_reg(index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stop offering and wait until every frame word is in, then let the block settle.
   task automatic wait_for_frames();
      req_tvalid <= 1'b0;
      while (frames.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly in-range sets and clears with regular updates, some noise.
   task automatic random_request();
      int         roll;
      int         active;
      logic [1:0] kind;
      logic [5:0] idx;
      roll   = $urandom_range(0, 99);
      active = frames.active_leds();
      if (roll < 45) kind = REQ_SET;
      else if (roll < 65) kind = REQ_CLEAR;
      else if (roll < 93) kind = REQ_UPDATE;
      else kind = REQ_UNUSED;
      if (active == 0 || $urandom_range(0, 9) == 0) idx = 6'($urandom_range(0, 63));
      else idx = 6'($urandom_range(0, active - 1));
      send_request(kind, idx, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   initial begin
      #2_000_000;
      $display("tb: errors");
      $finish;
   end

   initial begin
      int count_pick;
      logic [5:0] count_value;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      req_gaps   = 1'b1;
      rsp_stalls = 1'b1;

      // Reset values: empty store, full brightness, all 62 LEDs.
      send_request(REQ_UPDATE, 6'd0, 8'h00, 8'h00, 8'h00);
      send_request(REQ_SET, 6'd0, 8'hFF, 8'h00, 8'hFF);
      send_request(REQ_SET, 6'd61, 8'h00, 8'hFF, 8'h00);
      send_request(REQ_SET, 6'd30, 8'hA5, 8'h5A, 8'hC3);
      // Indexes past the LED count and the unused code change nothing; LED 61 is cleared and set.
      send_request(REQ_SET, 6'd62, 8'hFF, 8'hFF, 8'hFF);
      send_request(REQ_SET, 6'd63, 8'hFF, 8'hFF, 8'hFF);
      send_request(REQ_CLEAR, 6'd61, 8'h00, 8'h00, 8'h00);
      send_request(REQ_CLEAR, 6'd63, 8'hFF, 8'hFF, 8'hFF);
      send_request(REQ_UNUSED, 6'd5, 8'hFF, 8'hFF, 8'hFF);
      send_request(REQ_UPDATE, 6'd63, 8'hFF, 8'hFF, 8'hFF);
      send_request(REQ_SET, 6'd61, 8'hFF, 8'hFF, 8'hFF);
      send_request(REQ_UPDATE, 6'd0, 8'h00, 8'h00, 8'h00);
      wait_for_frames();

      // No LEDs in use: only start and end words, and every set is dropped.
      write_reg(CSR_BRIGHTNESS, 6'd0);
      write_reg(CSR_LED_COUNT, 6'd0);
      send_request(REQ_SET, 6'd0, 8'h11, 8'h22, 8'h33);
      send_request(REQ_UPDATE, 6'd0, 8'h00, 8'h00, 8'h00);
      wait_for_frames();

      // Brightness bit 5 is dropped; a count of 63 acts as 62.
      write_reg(CSR_BRIGHTNESS, 6'h3F);
      write_reg(CSR_LED_COUNT, 6'd63);
      send_request(REQ_SET, 6'd61, 8'h00, 8'h00, 8'h01);
      send_request(REQ_UPDATE, 6'd0, 8'h00, 8'h00, 8'h00);
      wait_for_frames();

      // Single LED.
      write_reg(CSR_BRIGHTNESS, 6'd1);
      write_reg(CSR_LED_COUNT, 6'd1);
      send_request(REQ_SET, 6'd0, 8'h12, 8'h34, 8'h56);
      send_request(REQ_SET, 6'd1, 8'h78, 8'h9A, 8'hBC);
      send_request(REQ_UPDATE, 6'd0, 8'h00, 8'h00, 8'h00);
      wait_for_frames();

      // Hold the sink off during a full frame so the block backs up into the input.
      write_reg(CSR_BRIGHTNESS, 6'd21);
      write_reg(CSR_LED_COUNT, 6'd62);
      long_hold = 1'b1;
      send_request(REQ_UPDATE, 6'd0, 8'h00, 8'h00, 8'h00);
      send_request(REQ_SET, 6'd2, 8'hDE, 8'hAD, 8'hBE);
      send_request(REQ_SET, 6'd40, 8'h01, 8'h02, 8'h03);
      send_request(REQ_CLEAR, 6'd0, 8'h00, 8'h00, 8'h00);
      send_request(REQ_UPDATE, 6'd0, 8'h00, 8'h00, 8'h00);
      wait_for_frames();

      // Random phases, each with its own register setting; the last one runs flat out.
      for (int phase = 0; phase < 6; phase++) begin
         count_pick = $urandom_range(0, 9);
         if (count_pick == 0) count_value = 6'd0;
         else if (count_pick == 1) count_value = 6'd62;
         else if (count_pick == 2) count_value = 6'd63;
         else count_value = 6'($urandom_range(1, 10));
         write_reg(CSR_BRIGHTNESS, 6'($urandom_range(0, 63)));
         write_reg(CSR_LED_COUNT, count_value);
         req_gaps   = (phase < 5) && ($urandom_range(0, 2) != 0);
         rsp_stalls = (phase < 5) && ($urandom_range(0, 2) != 0);
         for (int n = 0; n < 16; n++) random_request();
         wait_for_frames();
      end

      repeat (50) @(posedge clock);
      if (frames.errors == 0 && frames.pending() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
